@@ src/awrs_pkg.sv @@
// Shared types and constants for the stop-and-wait acknowledgment sender.
// Used by the channel interfaces, the sender core and the top level.
package awrs_pkg;

  // Field widths
  localparam int unsigned OpcodeW = 2;
  localparam int unsigned NodeW   = 16;
  localparam int unsigned IdW     = 16;
  localparam int unsigned ProtoW  = 8;
  localparam int unsigned ActionW = 2;
  localparam int unsigned AttemptW = 3;
  localparam int unsigned TicksW  = 16;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 16;

  // Input opcodes
  localparam logic [OpcodeW-1:0] OP_START = 2'd0;
  localparam logic [OpcodeW-1:0] OP_ID    = 2'd1;
  localparam logic [OpcodeW-1:0] OP_TICK  = 2'd2;
  localparam logic [OpcodeW-1:0] OP_FRAME = 2'd3;

  // Result actions
  localparam logic [ActionW-1:0] ACT_NONE      = 2'd0;
  localparam logic [ActionW-1:0] ACT_TRANSMIT  = 2'd1;
  localparam logic [ActionW-1:0] ACT_CONFIRMED = 2'd2;
  localparam logic [ActionW-1:0] ACT_FAILED    = 2'd3;

  // Protocol number of an acknowledgment frame
  localparam logic [ProtoW-1:0] ACK_PROTOCOL = 8'd1;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_TIMEOUT  = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_MAX_ATT  = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_BACKOFF  = 2'd2;

  // Configuration reset values
  localparam logic [TicksW-1:0]   TIMEOUT_RST = 16'd15000;
  localparam logic [AttemptW-1:0] MAX_ATT_RST = 3'd3;
  localparam logic [TicksW-1:0]   BACKOFF_RST = 16'd3000;

  typedef struct packed {
    logic [OpcodeW-1:0] opcode;
    logic [NodeW-1:0]   dest_node;
    logic [IdW-1:0]     assigned_id;
    logic [ProtoW-1:0]  rx_protocol;
    logic [NodeW-1:0]   rx_source;
    logic [IdW-1:0]     rx_ack_id;
  } awrs_item_t;

  typedef struct packed {
    logic [ActionW-1:0]  action;
    logic [AttemptW-1:0] attempt_number;
  } awrs_res_t;

  typedef struct packed {
    logic [TicksW-1:0]   timeout_ticks;
    logic [AttemptW-1:0] max_attempts;
    logic [TicksW-1:0]   backoff_ticks;
  } awrs_cfg_t;

endpackage

@@ src/awrs_in_if.sv @@
// Input channel of the sender: valid/ready handshake with one event item.
// Depends on awrs_pkg for field widths.
interface awrs_in_if;
  import awrs_pkg::*;

  logic                valid;
  logic                ready;
  logic [OpcodeW-1:0]  opcode;
  logic [NodeW-1:0]    dest_node;
  logic [IdW-1:0]      assigned_id;
  logic [ProtoW-1:0]   rx_protocol;
  logic [NodeW-1:0]    rx_source;
  logic [IdW-1:0]      rx_ack_id;

  modport source (
    output valid, opcode, dest_node, assigned_id, rx_protocol, rx_source, rx_ack_id,
    input  ready
  );

  modport sink (
    input  valid, opcode, dest_node, assigned_id, rx_protocol, rx_source, rx_ack_id,
    output ready
  );
endinterface

@@ src/awrs_out_if.sv @@
// Output channel of the sender: valid/ready handshake with one result item.
// Depends on awrs_pkg for field widths.
interface awrs_out_if;
  import awrs_pkg::*;

  logic                valid;
  logic                ready;
  logic [ActionW-1:0]  action;
  logic [AttemptW-1:0] attempt_number;

  modport source (
    output valid, action, attempt_number,
    input  ready
  );

  modport sink (
    input  valid, action, attempt_number,
    output ready
  );
endinterface

@@ src/awrs_core.sv @@
// Sender state machine: phase, attempt count, tick counter, target and id.
// Depends on awrs_pkg for item, result and configuration types.
module awrs_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                take_i,
  input  awrs_pkg::awrs_item_t item_i,
  input  awrs_pkg::awrs_cfg_t  cfg_i,
  output awrs_pkg::awrs_res_t  res_o
);
  import awrs_pkg::*;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_AWAIT_ID,
    PH_WAIT,
    PH_BACKOFF
  } phase_e;

  phase_e              phase_q, phase_d;
  logic [AttemptW-1:0] attempts_q, attempts_d;
  logic [TicksW-1:0]   elapsed_q, elapsed_d;
  logic [NodeW-1:0]    target_q, target_d;
  logic [IdW-1:0]      expected_q, expected_d;

  logic [TicksW-1:0]   elapsed_inc;
  logic [AttemptW-1:0] attempts_inc;
  logic [ActionW-1:0]  action;

  assign elapsed_inc  = elapsed_q + TicksW'(1);
  assign attempts_inc = attempts_q + AttemptW'(1);

  // Next state and action for the item at hand.
  always_comb begin
    phase_d    = phase_q;
    attempts_d = attempts_q;
    elapsed_d  = elapsed_q;
    target_d   = target_q;
    expected_d = expected_q;
    action     = ACT_NONE;

    unique case (item_i.opcode)
      OP_START: begin
        // A start always drops whatever send was running.
        target_d   = item_i.dest_node;
        attempts_d = '0;
        phase_d    = PH_AWAIT_ID;
        elapsed_d  = '0;
        action     = ACT_TRANSMIT;
      end
      OP_ID: begin
        if (phase_q == PH_AWAIT_ID) begin
          expected_d = item_i.assigned_id;
          elapsed_d  = '0;
          phase_d    = PH_WAIT;
        end
      end
      OP_TICK: begin
        if (phase_q == PH_WAIT) begin
          elapsed_d = elapsed_inc;
          if (elapsed_inc >= cfg_i.timeout_ticks) begin
            attempts_d = attempts_inc;
            if (attempts_inc < cfg_i.max_attempts) begin
              elapsed_d = '0;
              if (cfg_i.backoff_ticks == '0) begin
                phase_d = PH_AWAIT_ID;
                action  = ACT_TRANSMIT;
              end else begin
                phase_d = PH_BACKOFF;
              end
            end else begin
              phase_d   = PH_IDLE;
              elapsed_d = '0;
              action    = ACT_FAILED;
            end
          end
        end else if (phase_q == PH_BACKOFF) begin
          elapsed_d = elapsed_inc;
          if (elapsed_inc >= cfg_i.backoff_ticks) begin
            phase_d   = PH_AWAIT_ID;
            elapsed_d = '0;
            action    = ACT_TRANSMIT;
          end
        end
      end
      OP_FRAME: begin
        // Only a matching acknowledgment during the wait counts.
        if (phase_q == PH_WAIT && item_i.rx_protocol == ACK_PROTOCOL &&
            item_i.rx_source == target_q && item_i.rx_ack_id == expected_q) begin
          phase_d   = PH_IDLE;
          elapsed_d = '0;
          action    = ACT_CONFIRMED;
        end
      end
      default: ;
    endcase
  end

  // A confirmation counts the attempt that was acknowledged.
  assign res_o.action         = action;
  assign res_o.attempt_number = (action == ACT_CONFIRMED) ? attempts_inc : attempts_d;

  // State registers, updated once per item taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_IDLE;
      attempts_q <= '0;
      elapsed_q  <= '0;
      target_q   <= '0;
      expected_q <= '0;
    end else if (take_i) begin
      phase_q    <= phase_d;
      attempts_q <= attempts_d;
      elapsed_q  <= elapsed_d;
      target_q   <= target_d;
      expected_q <= expected_d;
    end
  end

`ifndef ASSERT_OFF
  // No time is counted before the packet id is known.
  a_no_count_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_IDLE || phase_q == PH_AWAIT_ID) |-> elapsed_q == '0)
    else $error("tick counter running outside wait or backoff");

  // A failure or confirmation ends the send.
  a_end_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take_i && (action == ACT_FAILED || action == ACT_CONFIRMED)) |=> phase_q == PH_IDLE)
    else $error("send not ended after final result");

  // A transmit request always waits for a new packet id.
  a_tx_await: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take_i && action == ACT_TRANSMIT) |=> phase_q == PH_AWAIT_ID)
    else $error("transmit request without waiting for the packet id");
`endif
endmodule

@@ src/ack_wait_retry_sender.sv @@
// Top level of the stop-and-wait acknowledgment sender.
// Depends on awrs_pkg, awrs_in_if, awrs_out_if and awrs_core.
//
// The sender accepts one event item per clock cycle and returns exactly one
// result item for each, in order. An item is taken into an input register,
// and as it moves on, a single pass of compare-and-count logic updates the send
// state and loads the result register, from which the result can be taken; the
// sustained rate is one item per cycle as long as the result side takes items.
// The result register and the input register together let a new item enter
// while a finished result still waits.
// Configuration registers are written through the plain write port and must
// only be changed while no items are in flight.
module ack_wait_retry_sender (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  awrs_in_if.sink                       in_if,
  awrs_out_if.source                    out_if,
  input  logic                          cfg_we_i,
  input  logic [awrs_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [awrs_pkg::CfgDataW-1:0] cfg_data_i
);
  import awrs_pkg::*;

  awrs_cfg_t  cfg_q;
  awrs_item_t in_q;
  logic       in_valid_q;
  awrs_res_t  out_q;
  logic       out_valid_q;
  awrs_res_t  res;
  logic       advance;

  // Item moves from input register to result register.
  assign advance     = in_valid_q && (!out_valid_q || out_if.ready);
  assign in_if.ready = !in_valid_q || advance;

  assign out_if.valid          = out_valid_q;
  assign out_if.action         = out_q.action;
  assign out_if.attempt_number = out_q.attempt_number;

  // Configuration registers; writes to unknown indexes are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.timeout_ticks <= TIMEOUT_RST;
      cfg_q.max_attempts  <= MAX_ATT_RST;
      cfg_q.backoff_ticks <= BACKOFF_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_TIMEOUT: cfg_q.timeout_ticks <= cfg_data_i;
        CFG_MAX_ATT: cfg_q.max_attempts  <= cfg_data_i[AttemptW-1:0];
        CFG_BACKOFF: cfg_q.backoff_ticks <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_if.ready) begin
      in_valid_q <= in_if.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_if.ready && in_if.valid) begin
      in_q.opcode      <= in_if.opcode;
      in_q.dest_node   <= in_if.dest_node;
      in_q.assigned_id <= in_if.assigned_id;
      in_q.rx_protocol <= in_if.rx_protocol;
      in_q.rx_source   <= in_if.rx_source;
      in_q.rx_ack_id   <= in_if.rx_ack_id;
    end
  end

  // Send state machine.
  awrs_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .take_i (advance),
    .item_i (in_q),
    .cfg_i  (cfg_q),
    .res_o  (res)
  );

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= res;
    end
  end

`ifndef ASSERT_OFF
  // An item that may move always lands in the result register.
  a_item_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_valid_q)
    else $error("item lost between input and result registers");

  // A held input item stays while the result side is blocked.
  a_input_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !advance) |=> in_valid_q)
    else $error("input item dropped without moving on");

  // The input register takes no item while it holds one that cannot move.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && out_valid_q && !out_if.ready) |-> !in_if.ready)
    else $error("input register open while full and blocked");
`endif
endmodule

@@ dv/tb_ack_wait_retry_sender.sv @@
// Self-checking testbench for the stop-and-wait acknowledgment sender.
// Depends on awrs_pkg, awrs_in_if, awrs_out_if and the ack_wait_retry_sender RTL.
// A scoreboard predicts one result per event item; random gaps and stalls hit both channels.
module tb_ack_wait_retry_sender;
  timeunit 1ns;
  timeprecision 1ps;

  import awrs_pkg::*;

  localparam int unsigned QuietLimit   = 2000;
  localparam int unsigned SettleCycles = 6;
  localparam int unsigned MaxPrinted   = 100;
  localparam int unsigned RandPhases   = 8;
  localparam int unsigned PhaseItems   = 125;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_AWAIT_ID,
    PH_WAIT,
    PH_BACKOFF
  } send_phase_e;

  // Tracks the send state of the block and queues the result expected for each item.
  class send_outcome_board;
    logic [TicksW-1:0]   timeout_ticks;
    logic [AttemptW-1:0] max_attempts;
    logic [TicksW-1:0]   backoff_ticks;
    send_phase_e         phase;
    logic [AttemptW-1:0] attempts_done;
    logic [TicksW-1:0]   elapsed;
    logic [NodeW-1:0]    target;
    logic [IdW-1:0]      expected_id;
    awrs_res_t           pending_outcomes[$];

    function new();
      timeout_ticks = TIMEOUT_RST;
      max_attempts  = MAX_ATT_RST;
      backoff_ticks = BACKOFF_RST;
      phase         = PH_IDLE;
      attempts_done = '0;
      elapsed       = '0;
      target        = '0;
      expected_id   = '0;
    endfunction

    function void set_register(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
      case (idx)
        CFG_TIMEOUT: timeout_ticks = data[TicksW-1:0];
        CFG_MAX_ATT: max_attempts  = data[AttemptW-1:0];
        CFG_BACKOFF: backoff_ticks = data[TicksW-1:0];
        default: ;
      endcase
    endfunction

    function logic [ActionW-1:0] begin_transmit();
      phase   = PH_AWAIT_ID;
      elapsed = '0;
      return ACT_TRANSMIT;
    endfunction

    // Advances the send state by one accepted item and queues its result.
    function void note_event(awrs_item_t it);
      logic [ActionW-1:0] act;
      awrs_res_t          res;
      act = ACT_NONE;
      case (it.opcode)
        OP_START: begin
          target        = it.dest_node;
          attempts_done = '0;
          act           = begin_transmit();
        end
        OP_ID: begin
          if (phase == PH_AWAIT_ID) begin
            expected_id = it.assigned_id;
            elapsed     = '0;
            phase       = PH_WAIT;
          end
        end
        OP_TICK: begin
          if (phase == PH_WAIT) begin
            elapsed = elapsed + 1'b1;
            if (elapsed >= timeout_ticks) begin
              attempts_done = attempts_done + 1'b1;
              if (attempts_done < max_attempts) begin
                if (backoff_ticks == '0) begin
                  act = begin_transmit();
                end else begin
                  phase   = PH_BACKOFF;
                  elapsed = '0;
                end
              end else begin
                phase   = PH_IDLE;
                elapsed = '0;
                act     = ACT_FAILED;
              end
            end
          end else if (phase == PH_BACKOFF) begin
            elapsed = elapsed + 1'b1;
            if (elapsed >= backoff_ticks) begin
              act = begin_transmit();
            end
          end
        end
        default: begin
          if (phase == PH_WAIT && it.rx_protocol == ACK_PROTOCOL &&
              it.rx_source == target && it.rx_ack_id == expected_id) begin
            phase   = PH_IDLE;
            elapsed = '0;
            act     = ACT_CONFIRMED;
          end
        end
      endcase
      res.action = act;
      // A confirmation counts the attempt that succeeded.
      res.attempt_number = (act == ACT_CONFIRMED) ? attempts_done + 1'b1 : attempts_done;
      pending_outcomes = {pending_outcomes, res};
    endfunction

    // Compares a result with the oldest expectation; returns an empty string on a match.
    function string check_outcome(awrs_res_t got);
      awrs_res_t want;
      string     msg = "";
      if (pending_outcomes.size() == 0) begin
        return $sformatf("unexpected result action=%0d attempt=%0d",
                         got.action, got.attempt_number);
      end
      want = pending_outcomes.pop_front();
      if (got.action !== want.action) begin
        msg = {msg, $sformatf(" action got %0d want %0d", got.action, want.action)};
      end
      if (got.attempt_number !== want.attempt_number) begin
        msg = {msg, $sformatf(" attempt got %0d want %0d",
                              got.attempt_number, want.attempt_number)};
      end
      return msg;
    endfunction

    function int unsigned pending();
      return pending_outcomes.size();
    endfunction
  endclass

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_data_i;

  awrs_in_if  ev_ch ();
  awrs_out_if res_ch ();

  ack_wait_retry_sender dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_if      (ev_ch),
    .out_if     (res_ch),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  send_outcome_board tracker = new();
  int unsigned       error_count = 0;
  int unsigned       quiet_cycles = 0;
  bit                src_gaps_on = 1'b1;
  bit                sink_stalls_on = 1'b1;
  awrs_res_t         seen_res;
  string             seen_msg;

  // Free-running clock.
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Prints one line per mismatch, up to a cap, and counts every one.
  task automatic report_mismatch(string msg);
    error_count++;
    if (error_count <= MaxPrinted) begin
      $display("MISMATCH at %0t:%s", $time, msg);
    end
  endtask

  function automatic awrs_item_t make_event(logic [OpcodeW-1:0] op, logic [NodeW-1:0] dest,
                                            logic [IdW-1:0] aid, logic [ProtoW-1:0] proto,
                                            logic [NodeW-1:0] src, logic [IdW-1:0] ack);
    awrs_item_t it;
    it.opcode      = op;
    it.dest_node   = dest;
    it.assigned_id = aid;
    it.rx_protocol = proto;
    it.rx_source   = src;
    it.rx_ack_id   = ack;
    return it;
  endfunction

  function automatic awrs_item_t noise_event(logic [OpcodeW-1:0] op);
    return make_event(op, NodeW'($urandom), IdW'($urandom), ProtoW'($urandom),
                      NodeW'($urandom), IdW'($urandom));
  endfunction

  // Chooses the next random item from the current phase, mostly the event that moves
  // the send forward, with noise and near-miss acknowledgments mixed in.
  function automatic awrs_item_t pick_event();
    awrs_item_t         it;
    int unsigned        roll;
    logic [OpcodeW-1:0] op;
    roll = $urandom_range(0, 99);
    case (tracker.phase)
      PH_IDLE:     op = (roll < 70) ? OP_START : OpcodeW'($urandom);
      PH_AWAIT_ID: op = (roll < 75) ? OP_ID : (roll < 85) ? OP_START : OpcodeW'($urandom);
      PH_WAIT:     op = (roll < 55) ? OP_TICK : (roll < 90) ? OP_FRAME :
                        (roll < 95) ? OP_START : OP_ID;
      default:     op = (roll < 85) ? OP_TICK : OpcodeW'($urandom);
    endcase
    it = noise_event(op);
    if (op == OP_FRAME && $urandom_range(0, 2) != 0) begin
      it.rx_protocol = ACK_PROTOCOL;
      it.rx_source   = tracker.target;
      it.rx_ack_id   = tracker.expected_id;
      // Sometimes break exactly one of the three match conditions.
      case ($urandom_range(0, 5))
        0: it.rx_protocol = it.rx_protocol ^ (ProtoW'(1) << $urandom_range(0, ProtoW-1));
        1: it.rx_source   = it.rx_source ^ (NodeW'(1) << $urandom_range(0, NodeW-1));
        2: it.rx_ack_id   = it.rx_ack_id ^ (IdW'(1) << $urandom_range(0, IdW-1));
        default: ;
      endcase
    end
    return it;
  endfunction

  // Offers one item, waits for the handshake, then maybe leaves a gap.
  task automatic push_event(awrs_item_t it);
    ev_ch.valid       <= 1'b1;
    ev_ch.opcode      <= it.opcode;
    ev_ch.dest_node   <= it.dest_node;
    ev_ch.assigned_id <= it.assigned_id;
    ev_ch.rx_protocol <= it.rx_protocol;
    ev_ch.rx_source   <= it.rx_source;
    ev_ch.rx_ack_id   <= it.rx_ack_id;
    do @(posedge clk_i); while (!ev_ch.ready);
    tracker.note_event(it);
    if (src_gaps_on && $urandom_range(0, 9) == 0) begin
      ev_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk_i);
    end
  endtask

  task automatic push_ticks(int unsigned count);
    repeat (count) push_event(noise_event(OP_TICK));
  endtask

  // Holds the input off until every expected result is back and the block has settled.
  task automatic drain_results();
    ev_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (tracker.pending() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // Writes all three registers while the block is idle.
  task automatic load_config(logic [TicksW-1:0] tmo, logic [AttemptW-1:0] att,
                             logic [TicksW-1:0] bko);
    drain_results();
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_TIMEOUT;
    cfg_data_i <= CfgDataW'(tmo);
    @(posedge clk_i);
    cfg_idx_i  <= CFG_MAX_ATT;
    cfg_data_i <= CfgDataW'(att);
    @(posedge clk_i);
    cfg_idx_i  <= CFG_BACKOFF;
    cfg_data_i <= CfgDataW'(bko);
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    tracker.set_register(CFG_TIMEOUT, CfgDataW'(tmo));
    tracker.set_register(CFG_MAX_ATT, CfgDataW'(att));
    tracker.set_register(CFG_BACKOFF, CfgDataW'(bko));
  endtask

  // Result-side ready with random stall bursts.
  initial begin
    res_ch.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (sink_stalls_on && $urandom_range(0, 9) == 0) begin
        res_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk_i);
      end
      res_ch.ready <= 1'b1;
    end
  end

  // Checks every accepted result against the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni && res_ch.valid && res_ch.ready) begin
      seen_res.action         = res_ch.action;
      seen_res.attempt_number = res_ch.attempt_number;
      seen_msg = tracker.check_outcome(seen_res);
      if (seen_msg != "") begin
        report_mismatch(seen_msg);
      end
    end
  end

  // Ends the run when neither channel moves for too long.
  always @(posedge clk_i) begin
    if ((ev_ch.valid && ev_ch.ready) || (res_ch.valid && res_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QuietLimit) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  initial begin
    int unsigned tmo;
    int unsigned bko;

    rst_ni            <= 1'b0;
    cfg_we_i          <= 1'b0;
    cfg_idx_i         <= CFG_TIMEOUT;
    cfg_data_i        <= '0;
    ev_ch.valid       <= 1'b0;
    ev_ch.opcode      <= OP_TICK;
    ev_ch.dest_node   <= '0;
    ev_ch.assigned_id <= '0;
    ev_ch.rx_protocol <= '0;
    ev_ch.rx_source   <= '0;
    ev_ch.rx_ack_id   <= '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Directed: ignored events in idle and await id, bad acknowledgments, a good one,
    // and a restart while a send is running. Reset register values apply here.
    push_event(make_event(OP_TICK, 16'h0000, 16'h0000, 8'h00, 16'h0000, 16'h0000));
    push_event(make_event(OP_ID, 16'h0000, 16'h1234, 8'h00, 16'h0000, 16'h0000));
    push_event(make_event(OP_FRAME, 16'h0000, 16'h0000, 8'h01, 16'h0000, 16'h0000));
    push_event(make_event(OP_START, 16'hFFFF, 16'h0000, 8'h00, 16'h0000, 16'h0000));
    push_event(make_event(OP_TICK, 16'h0000, 16'h0000, 8'h00, 16'h0000, 16'h0000));
    push_event(make_event(OP_FRAME, 16'h0000, 16'h0000, 8'h01, 16'hFFFF, 16'h0000));
    push_event(make_event(OP_ID, 16'h0000, 16'hFFFF, 8'h00, 16'h0000, 16'h0000));
    push_event(make_event(OP_ID, 16'h0000, 16'h0000, 8'h00, 16'h0000, 16'h0000));
    push_event(make_event(OP_FRAME, 16'h0000, 16'h0000, 8'hFF, 16'hFFFF, 16'hFFFF));
    push_event(make_event(OP_FRAME, 16'h0000, 16'h0000, 8'h01, 16'h0000, 16'hFFFF));
    push_event(make_event(OP_FRAME, 16'h0000, 16'h0000, 8'h01, 16'hFFFF, 16'h0000));
    push_event(make_event(OP_TICK, 16'h0000, 16'h0000, 8'h00, 16'h0000, 16'h0000));
    push_event(make_event(OP_FRAME, 16'h0000, 16'h0000, 8'h01, 16'hFFFF, 16'hFFFF));
    push_event(make_event(OP_FRAME, 16'h0000, 16'h0000, 8'h01, 16'hFFFF, 16'hFFFF));
    push_event(make_event(OP_START, 16'h0000, 16'h0000, 8'h00, 16'h0000, 16'h0000));
    push_event(make_event(OP_ID, 16'h0000, 16'h0000, 8'h00, 16'h0000, 16'h0000));
    push_event(make_event(OP_START, 16'hA5A5, 16'h0000, 8'h00, 16'h0000, 16'h0000));
    push_event(make_event(OP_ID, 16'h0000, 16'h5A5A, 8'h00, 16'h0000, 16'h0000));
    push_event(make_event(OP_FRAME, 16'h0000, 16'h0000, 8'h01, 16'hA5A5, 16'h5A5A));

    // Zero timeout and zero attempts: the first tick fails the only attempt.
    load_config(16'd0, 3'd0, 16'd0);
    push_event(make_event(OP_START, 16'h3C3C, 16'h0000, 8'h00, 16'h0000, 16'h0000));
    push_event(make_event(OP_ID, 16'h0000, 16'hC3C3, 8'h00, 16'h0000, 16'h0000));
    push_ticks(1);

    // Zero backoff, seven attempts: each timeout but the last retransmits on the same tick.
    load_config(16'd0, 3'd7, 16'd0);
    push_event(make_event(OP_START, 16'h0F0F, 16'h0000, 8'h00, 16'h0000, 16'h0000));
    for (int k = 0; k < 7; k++) begin
      push_event(make_event(OP_ID, 16'h0000, 16'(k), 8'h00, 16'h0000, 16'h0000));
      push_ticks(1);
    end

    // One backoff, then a confirmation on the second attempt.
    load_config(16'd1, 3'd2, 16'd1);
    push_event(make_event(OP_START, 16'h1111, 16'h0000, 8'h00, 16'h0000, 16'h0000));
    push_event(make_event(OP_ID, 16'h0000, 16'h2222, 8'h00, 16'h0000, 16'h0000));
    push_ticks(2);
    push_event(make_event(OP_ID, 16'h0000, 16'h3333, 8'h00, 16'h0000, 16'h0000));
    push_event(make_event(OP_FRAME, 16'h0000, 16'h0000, 8'h01, 16'h1111, 16'h3333));

    // Largest timeout and backoff: a burst of ticks far below the timeout, then a
    // confirmation of the first attempt.
    load_config(16'hFFFF, 3'd2, 16'hFFFF);
    push_event(make_event(OP_START, 16'h7E7E, 16'h0000, 8'h00, 16'h0000, 16'h0000));
    push_event(make_event(OP_ID, 16'h0000, 16'hE7E7, 8'h00, 16'h0000, 16'h0000));
    push_ticks(20);
    push_event(make_event(OP_FRAME, 16'h0000, 16'h0000, 8'h01, 16'h7E7E, 16'hE7E7));

    // Random phases with small timing settings; the fourth and the last run without idling.
    for (int p = 0; p < RandPhases; p++) begin
      tmo = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      bko = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      load_config(TicksW'(tmo), AttemptW'($urandom_range(0, 7)), TicksW'(bko));
      src_gaps_on    = (p != 3) && (p != RandPhases - 1);
      sink_stalls_on = (p != 3) && (p != RandPhases - 1);
      for (int n = 0; n < PhaseItems; n++) begin
        push_event(pick_event());
        // Now and then the bench holds off until all results are back.
        if (src_gaps_on && $urandom_range(0, 99) == 0) begin
          drain_results();
        end
      end
    end

    drain_results();
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
